@@ rtl/sd_spi_data_block_receiver_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the SD SPI data block receiver.
// Concurrent checks clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_DATA_BLOCK_RECEIVER_ASSERT_SVH
`define SD_SPI_DATA_BLOCK_RECEIVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDRX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDRX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sdrx_pkg.sv @@
// ----------------------------------------------------------------------------
// sdrx_pkg
// Types and constants shared by the SD SPI data block receiver modules.
// ----------------------------------------------------------------------------
package sdrx_pkg;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CRC_W = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_W = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned MAX_BLOCK = 512;
	localparam int unsigned LEN_MAX_CODE = (1 << LEN_W) - 1;
	localparam int unsigned LEN_CAP_INT = (MAX_BLOCK < LEN_MAX_CODE) ? MAX_BLOCK : LEN_MAX_CODE;
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_INT);

	localparam int unsigned QDEPTH = 2;

	localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BYTE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

	localparam logic [BYTE_W-1:0] START_TOKEN = 8'hFE;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd200;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CRC_BAD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TOKEN_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERIFY_CRC = 1'd1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] rx_byte;
		logic [LEN_W-1:0] block_length;
	} sdrx_req_t;

	typedef struct packed {
		logic result_kind;
		logic [BYTE_W-1:0] data_byte;
		logic [STATUS_W-1:0] status;
	} sdrx_rsp_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_BYTE,
		OP_TICK
	} sdrx_op_t;

	typedef struct packed {
		sdrx_op_t op;
		logic [BYTE_W-1:0] data;
		logic is_token;
		logic [LEN_W-1:0] len;
	} sdrx_cmd_t;

	typedef struct packed {
		logic valid;
		sdrx_cmd_t cmd;
	} sdrx_slot_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_DATA,
		PH_CRCH,
		PH_CRCL
	} sdrx_phase_t;

endpackage

@@ rtl/sdrx_front.sv @@
// ----------------------------------------------------------------------------
// sdrx_front
// Accepts requests, decodes the function code and queues commands.
// ----------------------------------------------------------------------------
module sdrx_front #(
	parameter int unsigned MAX_BLOCK = sdrx_pkg::MAX_BLOCK
) (
	input  logic               req_valid,
	output logic               req_stall,
	input  sdrx_pkg::sdrx_req_t req,
	input  logic               queue_full,
	output sdrx_pkg::sdrx_slot_t push
);
	import sdrx_pkg::*;

	localparam int unsigned BLOCK_CAP_INT =
		(MAX_BLOCK < LEN_MAX_CODE) ? MAX_BLOCK : LEN_MAX_CODE;
	localparam logic [LEN_W-1:0] BLOCK_CAP = LEN_W'(BLOCK_CAP_INT);

	logic accept;
	logic known;
	sdrx_op_t op;

	assign req_stall = queue_full;
	assign accept = req_valid && !queue_full;

	always_comb begin
		known = 1'b1;
		op = OP_START;
		case (req.func)
			FUNC_START: begin
				op = OP_START;
			end
			FUNC_BYTE: begin
				op = OP_BYTE;
			end
			FUNC_TICK: begin
				op = OP_TICK;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	always_comb begin
		push.valid = accept && known;
		push.cmd.op = op;
		push.cmd.data = req.rx_byte;
		push.cmd.is_token = (req.rx_byte == START_TOKEN);
		push.cmd.len = (req.block_length > BLOCK_CAP) ? BLOCK_CAP : req.block_length;
	end

endmodule

@@ rtl/sdrx_queue.sv @@
// ----------------------------------------------------------------------------
// sdrx_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sdrx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  sdrx_pkg::sdrx_slot_t push,
	output logic                full,
	output sdrx_pkg::sdrx_slot_t head,
	input  logic                pop
);
	import sdrx_pkg::*;

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

	sdrx_cmd_t slots_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_FULL);
	assign do_push = push.valid && !full;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/sdrx_back.sv @@
// ----------------------------------------------------------------------------
// sdrx_back
// Block reception state machine, CRC16 update and registered response.
// ----------------------------------------------------------------------------
module sdrx_back #(
	parameter int unsigned MAX_BLOCK = sdrx_pkg::MAX_BLOCK
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [sdrx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdrx_pkg::CFG_W-1:0]     cfg_wdata,
	input  sdrx_pkg::sdrx_slot_t head,
	output logic                pop,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sdrx_pkg::sdrx_rsp_t rsp
);
	import sdrx_pkg::*;

	localparam int unsigned BLOCK_CAP_INT =
		(MAX_BLOCK < LEN_MAX_CODE) ? MAX_BLOCK : LEN_MAX_CODE;
	localparam logic [LEN_W-1:0] BLOCK_CAP = LEN_W'(BLOCK_CAP_INT);

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {b, {(CRC_W - BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

	logic [TICK_W-1:0] token_timeout_q;
	logic verify_crc_q;

	sdrx_phase_t phase_q;
	sdrx_phase_t phase_d;
	logic [TICK_W-1:0] wait_ticks_q;
	logic [LEN_W-1:0] bytes_left_q;
	logic [CRC_W-1:0] running_crc_q;
	logic [BYTE_W-1:0] card_crc_high_q;

	logic rsp_valid_q;
	sdrx_rsp_t rsp_q;

	sdrx_cmd_t cmd;
	logic [TICK_W-1:0] ticks_inc;
	logic [TICK_W-1:0] limit;
	logic tick_hit;
	logic last_byte;
	logic crc_bad;
	logic [CRC_W-1:0] crc_next;
	logic res_fire;
	sdrx_rsp_t res_d;

	assign cmd = head.cmd;
	assign pop = head.valid && (!rsp_valid_q || !rsp_stall);

	assign ticks_inc = (wait_ticks_q == {TICK_W{1'b1}}) ? wait_ticks_q : wait_ticks_q + 1'b1;
	assign limit = (token_timeout_q == '0) ? TICK_W'(1) : token_timeout_q;
	assign tick_hit = (ticks_inc >= limit);
	assign last_byte = (bytes_left_q == LEN_W'(1));
	assign crc_next = crc_byte(running_crc_q, cmd.data);
	assign crc_bad = verify_crc_q && ({card_crc_high_q, cmd.data} != running_crc_q);

	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			case (cmd.op)
				OP_START: begin
					phase_d = PH_WAIT;
				end
				OP_TICK: begin
					if (phase_q == PH_WAIT && tick_hit) begin
						phase_d = PH_IDLE;
					end
				end
				OP_BYTE: begin
					case (phase_q)
						PH_WAIT: begin
							if (cmd.is_token) begin
								phase_d = (bytes_left_q == '0) ? PH_CRCH : PH_DATA;
							end
						end
						PH_DATA: begin
							if (last_byte) begin
								phase_d = PH_CRCH;
							end
						end
						PH_CRCH: begin
							phase_d = PH_CRCL;
						end
						PH_CRCL: begin
							phase_d = PH_IDLE;
						end
						default: begin
							phase_d = phase_q;
						end
					endcase
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_comb begin
		res_fire = 1'b0;
		res_d.result_kind = KIND_STATUS;
		res_d.data_byte = '0;
		res_d.status = ST_OK;
		case (cmd.op)
			OP_TICK: begin
				if (phase_q == PH_WAIT && tick_hit) begin
					res_fire = 1'b1;
					res_d.status = ST_TIMEOUT;
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_DATA) begin
					res_fire = 1'b1;
					res_d.result_kind = KIND_DATA;
					res_d.data_byte = cmd.data;
				end else if (phase_q == PH_CRCL) begin
					res_fire = 1'b1;
					res_d.status = crc_bad ? ST_CRC_BAD : ST_OK;
				end
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_timeout_q <= TIMEOUT_RESET;
			verify_crc_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOKEN_TIMEOUT: begin
					token_timeout_q <= cfg_wdata[TICK_W-1:0];
				end
				REG_VERIFY_CRC: begin
					verify_crc_q <= cfg_wdata[0];
				end
				default: begin
					verify_crc_q <= verify_crc_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			wait_ticks_q <= '0;
			bytes_left_q <= '0;
			running_crc_q <= '0;
			card_crc_high_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (pop) begin
				case (cmd.op)
					OP_START: begin
						bytes_left_q <= cmd.len;
						wait_ticks_q <= '0;
						running_crc_q <= '0;
						card_crc_high_q <= '0;
					end
					OP_TICK: begin
						if (phase_q == PH_WAIT) begin
							wait_ticks_q <= ticks_inc;
						end
					end
					OP_BYTE: begin
						case (phase_q)
							PH_WAIT: begin
								if (cmd.is_token) begin
									running_crc_q <= '0;
								end
							end
							PH_DATA: begin
								running_crc_q <= crc_next;
								bytes_left_q <= bytes_left_q - 1'b1;
							end
							PH_CRCH: begin
								card_crc_high_q <= cmd.data;
							end
							default: begin
								card_crc_high_q <= card_crc_high_q;
							end
						endcase
					end
					default: begin
						wait_ticks_q <= wait_ticks_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (pop && res_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_fire) begin
			rsp_q <= res_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`include "sd_spi_data_block_receiver_assert.svh"

	`SDRX_ASSERT_SAME(a_data_has_bytes, clk, arst_n,
		phase_q == PH_DATA, bytes_left_q != '0,
		"Data phase entered with no bytes left.")
	`SDRX_ASSERT_SAME(a_len_capped, clk, arst_n,
		1'b1, bytes_left_q <= BLOCK_CAP,
		"Remaining byte count exceeds the block limit.")
	`SDRX_ASSERT_SAME(a_data_status_ok, clk, arst_n,
		rsp_valid_q && rsp_q.result_kind == KIND_DATA, rsp_q.status == ST_OK,
		"Data response carries a nonzero status.")
	`SDRX_ASSERT_NEXT(a_byte_gives_data, clk, arst_n,
		pop && cmd.op == OP_BYTE && phase_q == PH_DATA,
		rsp_valid_q && rsp_q.result_kind == KIND_DATA && rsp_q.data_byte == $past(cmd.data),
		"Data byte did not reach the response register.")

endmodule

@@ rtl/sd_spi_data_block_receiver.sv @@
// ----------------------------------------------------------------------------
// sd_spi_data_block_receiver
// Receives one SD SPI data block, checks its CRC16 when enabled and reports a status.
// ----------------------------------------------------------------------------
// The receiver takes one request per clock cycle while req_stall is low and
// gives at most one response per request: each data byte of the block, then
// one final status (ok, start token timeout or CRC mismatch). A response
// passes through the two-entry command queue and then the response register.
// The sustained rate of one request per cycle holds while rsp_stall is low
// and is set by the back end, which updates the CRC16 over a whole byte at
// once. Configuration writes take effect at once and belong between blocks.
module sd_spi_data_block_receiver #(
	parameter int unsigned MAX_BLOCK = sdrx_pkg::MAX_BLOCK
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sdrx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdrx_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  sdrx_pkg::sdrx_req_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output sdrx_pkg::sdrx_rsp_t            rsp
);
	import sdrx_pkg::*;

	sdrx_slot_t push;
	sdrx_slot_t head;
	logic queue_full;
	logic pop;

	sdrx_front #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.queue_full (queue_full),
		.push       (push)
	);

	sdrx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (queue_full),
		.head   (head),
		.pop    (pop)
	);

	sdrx_back #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
